// ----- rtl/mpts_pkg.sv -----
// mpts_pkg: shared types and constants of the memory pattern test sequencer
// used by mpts_front, mpts_engine and memory_pattern_test_sequencer_top
package mpts_pkg;

    localparam int ADDR_W  = 24;
    localparam int WORD_W  = 16;
    localparam int COUNT_W = 24;
    localparam int PAT_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [PAT_W-1:0]   RAND_SEED = 32'hABCDEF02;
    localparam logic [PAT_W-1:0]   ALT_SEED  = 32'hFFFFFFFF;
    localparam logic [PAT_W-1:0]   RAND_INC  = 32'd13849;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_ADDRESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_ON_ERROR = 2'd3;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic              is_start;
        logic [WORD_W-1:0] read_data;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start_address;
        logic [ADDR_W-1:0] end_address;
        logic              pattern_mode;
        logic              stop_on_error;
    } cfg_t;

endpackage

// ----- rtl/mpts_front.sv -----
// mpts_front: input handshake, item decode and two-entry queue to the engine
// depends on mpts_pkg

module mpts_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic [15:0]           read_data,
    output logic                  q_valid,
    input  logic                  q_ready,
    output mpts_pkg::item_t       q_item
);

    mpts_pkg::item_t entry_reg [2];
    mpts_pkg::item_t entry_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        entry_next.is_start  = (op == mpts_pkg::OP_START);
        entry_next.read_data = read_data;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= entry_next;
        end
    end

endmodule

// ----- rtl/mpts_engine.sv -----
// mpts_engine: test state, pattern generator, compare and result register
// depends on mpts_pkg

module mpts_engine
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mpts_pkg::cfg_t        cfg,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  mpts_pkg::item_t       q_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  mem_write,
    output logic                  mem_read,
    output logic [23:0]           mem_address,
    output logic [15:0]           write_data,
    output logic                  mismatch,
    output logic [23:0]           mismatch_address,
    output logic [15:0]           expected_word,
    output logic [23:0]           error_total,
    output logic                  test_done
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_WRITE = 2'd1;
    localparam logic [1:0] PH_READ  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam int AW = mpts_pkg::ADDR_W;
    localparam int WW = mpts_pkg::WORD_W;
    localparam int PW = mpts_pkg::PAT_W;
    localparam int CW = mpts_pkg::COUNT_W;

    logic [1:0]    phase_reg, phase_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [PW-1:0] pat_reg, pat_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic [WW-1:0] pend_exp_reg, pend_exp_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;

    logic          mem_write_reg, mem_write_next;
    logic          mem_read_reg, mem_read_next;
    logic [AW-1:0] mem_address_reg, mem_address_next;
    logic [WW-1:0] write_data_reg, write_data_next;
    logic          mismatch_reg, mismatch_next;
    logic [AW-1:0] mismatch_address_reg, mismatch_address_next;
    logic [WW-1:0] expected_word_reg, expected_word_next;

    logic          pop;
    logic [PW-1:0] seed;
    logic [PW-1:0] pat_step;
    logic [AW-1:0] cur_plus2;
    logic          wl_cur, wl_step, wl_start;
    logic          miss, stop;

    assign q_ready = !out_valid_reg || out_ready;
    assign pop     = q_valid && q_ready;

    assign seed      = cfg.pattern_mode ? mpts_pkg::ALT_SEED : mpts_pkg::RAND_SEED;
    assign pat_step  = cfg.pattern_mode ? ~pat_reg
                     : (pat_reg << 13) + (pat_reg << 2) + pat_reg + mpts_pkg::RAND_INC;
    assign cur_plus2 = cur_reg + AW'(2);

    assign wl_cur   = {1'b0, cfg.end_address} > ({1'b0, cur_reg} + (AW+1)'(1));
    assign wl_step  = {1'b0, cfg.end_address} > ({1'b0, cur_plus2} + (AW+1)'(1));
    assign wl_start = {1'b0, cfg.end_address} > ({1'b0, cfg.start_address} + (AW+1)'(1));

    assign miss = pend_reg && (q_item.read_data != pend_exp_reg);
    assign stop = miss && cfg.stop_on_error;

    always_comb
    begin
        phase_next     = phase_reg;
        cur_next       = cur_reg;
        pat_next       = pat_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        pend_exp_next  = pend_exp_reg;
        count_next     = count_reg;

        mem_write_next        = 1'b0;
        mem_read_next         = 1'b0;
        mem_address_next      = '0;
        write_data_next       = '0;
        mismatch_next         = 1'b0;
        mismatch_address_next = '0;
        expected_word_next    = '0;

        if (q_item.is_start)
        begin
            cur_next       = cfg.start_address;
            pat_next       = seed;
            pend_next      = 1'b0;
            pend_addr_next = '0;
            pend_exp_next  = '0;
            count_next     = '0;
            phase_next     = wl_start ? PH_WRITE : PH_DONE;
        end
        else
        begin
            case (phase_reg)
                PH_WRITE:
                begin
                    if (wl_cur)
                    begin
                        mem_write_next   = 1'b1;
                        mem_address_next = cur_reg;
                        write_data_next  = pat_step[WW-1:0];
                        pat_next         = pat_step;
                        cur_next         = cur_plus2;
                    end
                    if (!(wl_cur && wl_step))
                    begin
                        cur_next   = cfg.start_address;
                        pat_next   = seed;
                        phase_next = wl_start ? PH_READ : PH_DONE;
                    end
                end
                PH_READ:
                begin
                    if (pend_reg)
                    begin
                        mismatch_address_next = pend_addr_reg;
                        expected_word_next    = pend_exp_reg;
                        mismatch_next         = miss;
                        if (miss && count_reg != mpts_pkg::COUNT_MAX)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        pend_next = 1'b0;
                    end
                    if (stop || !wl_cur)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        mem_read_next    = 1'b1;
                        mem_address_next = cur_reg;
                        pend_next        = 1'b1;
                        pend_addr_next   = cur_reg;
                        pend_exp_next    = pat_step[WW-1:0];
                        pat_next         = pat_step;
                        cur_next         = cur_plus2;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cur_reg       <= '0;
            pat_reg       <= mpts_pkg::RAND_SEED;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            pend_exp_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg     <= phase_next;
                cur_reg       <= cur_next;
                pat_reg       <= pat_next;
                pend_reg      <= pend_next;
                pend_addr_reg <= pend_addr_next;
                pend_exp_reg  <= pend_exp_next;
                count_reg     <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mem_write_reg        <= mem_write_next;
            mem_read_reg         <= mem_read_next;
            mem_address_reg      <= mem_address_next;
            write_data_reg       <= write_data_next;
            mismatch_reg         <= mismatch_next;
            mismatch_address_reg <= mismatch_address_next;
            expected_word_reg    <= expected_word_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign mem_write        = mem_write_reg;
    assign mem_read         = mem_read_reg;
    assign mem_address      = mem_address_reg;
    assign write_data       = write_data_reg;
    assign mismatch         = mismatch_reg;
    assign mismatch_address = mismatch_address_reg;
    assign expected_word    = expected_word_reg;
    assign error_total      = count_reg;
    assign test_done        = (phase_reg == PH_DONE);

endmodule

// ----- rtl/memory_pattern_test_sequencer_top.sv -----
// memory_pattern_test_sequencer_top: configuration registers, front queue and engine
// depends on mpts_pkg, mpts_front, mpts_engine
//
// channel   direction  handshake             payload
// config    in         cfg_write             cfg_index, cfg_data
// item      in         in_valid / in_ready   op, read_data
// result    out        out_valid / out_ready mem_write .. test_done
//
// one item per cycle unless out_ready stalls; results pass the queue and result register
// the engine updates its state and pattern step as it takes each item from the queue
// in_ready stays high while the two-entry queue has room, whatever the result side does
// reset empties the queue and result register and restores the idle test state

module memory_pattern_test_sequencer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [15:0] read_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        mem_write,
    output logic        mem_read,
    output logic [23:0] mem_address,
    output logic [15:0] write_data,
    output logic        mismatch,
    output logic [23:0] mismatch_address,
    output logic [15:0] expected_word,
    output logic [23:0] error_total,
    output logic        test_done
);

    mpts_pkg::cfg_t  cfg_reg, cfg_next;
    logic            q_valid;
    logic            q_ready;
    mpts_pkg::item_t q_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                mpts_pkg::REG_START_ADDRESS: cfg_next.start_address = cfg_data;
                mpts_pkg::REG_END_ADDRESS:   cfg_next.end_address   = cfg_data;
                mpts_pkg::REG_PATTERN_MODE:  cfg_next.pattern_mode  = cfg_data[0];
                mpts_pkg::REG_STOP_ON_ERROR: cfg_next.stop_on_error = cfg_data[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_address <= 24'd0;
            cfg_reg.end_address   <= 24'd4096;
            cfg_reg.pattern_mode  <= 1'b0;
            cfg_reg.stop_on_error <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mpts_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .read_data (read_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item)
    );

    mpts_engine u_engine
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_item           (q_item),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .mem_write        (mem_write),
        .mem_read         (mem_read),
        .mem_address      (mem_address),
        .write_data       (write_data),
        .mismatch         (mismatch),
        .mismatch_address (mismatch_address),
        .expected_word    (expected_word),
        .error_total      (error_total),
        .test_done        (test_done)
    );

endmodule
